@@ src/cpwa_pkg.sv @@
// ----------------------------------------------------------------------------
// cpwa_pkg: shared types and constants for the clamped PID with angle wrap
// Fixed-point formats, field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package cpwa_pkg;

    localparam int COUNTS_PER_TURN = 8192;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam int GAIN_FRAC_BITS  = 16;

    localparam int DATA_W   = 16;                       // target, measured, drive
    localparam int GAIN_W   = 32;
    localparam int LIMIT_W  = 15;
    localparam int ERR_W    = DATA_W + 1;               // target - measured
    localparam int DERR_W   = ERR_W + 1;                // e - last error
    localparam int PROD_W   = GAIN_W + ERR_W;
    localparam int DPROD_W  = GAIN_W + DERR_W;
    localparam int ACC_W    = LIMIT_W + GAIN_FRAC_BITS + 1;
    localparam int ISUM_W   = DPROD_W;                  // acc + ki*e, no overflow
    localparam int PD_W     = DPROD_W + 1;
    localparam int SUM_W    = PD_W + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = GAIN_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_OUT_LIMIT   = 3'd3,
        REG_INTEG_LIMIT = 3'd4,
        REG_ANGLE_MODE  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] prop_gain;
        logic signed [GAIN_W-1:0] integ_gain;
        logic signed [GAIN_W-1:0] deriv_gain;
        logic [LIMIT_W-1:0]       out_limit;
        logic [LIMIT_W-1:0]       integ_limit;
        logic                     angle_mode;
    } cfg_t;

endpackage

@@ src/cpwa_cfg.sv @@
// ----------------------------------------------------------------------------
// cpwa_cfg: configuration register file
// Write-only registers for gains, limits and angle mode; all reset to zero.
// ----------------------------------------------------------------------------
module cpwa_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cpwa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cpwa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output cpwa_pkg::cfg_t                   cfg
);

    cpwa_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cpwa_pkg::cfg_idx_t'(cfg_addr))
                cpwa_pkg::REG_PROP_GAIN:
                    cfg_reg.prop_gain <= $signed(cfg_wdata[cpwa_pkg::GAIN_W-1:0]);
                cpwa_pkg::REG_INTEG_GAIN:
                    cfg_reg.integ_gain <= $signed(cfg_wdata[cpwa_pkg::GAIN_W-1:0]);
                cpwa_pkg::REG_DERIV_GAIN:
                    cfg_reg.deriv_gain <= $signed(cfg_wdata[cpwa_pkg::GAIN_W-1:0]);
                cpwa_pkg::REG_OUT_LIMIT:
                    cfg_reg.out_limit <= cfg_wdata[cpwa_pkg::LIMIT_W-1:0];
                cpwa_pkg::REG_INTEG_LIMIT:
                    cfg_reg.integ_limit <= cfg_wdata[cpwa_pkg::LIMIT_W-1:0];
                cpwa_pkg::REG_ANGLE_MODE:
                    cfg_reg.angle_mode <= cfg_wdata[0];
                default:
                    cfg_reg <= cfg_reg;     // unmapped index, ignored
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/clamped_pid_with_angle_wrap.sv @@
// ----------------------------------------------------------------------------
// clamped_pid_with_angle_wrap: positional PID with anti-windup clamp
// Fixed-point PID (Q16.16 gains) with optional shortest-path angle error.
// An item passes the input, error, product, integral and drive registers in that order.
// Throughput: one item per cycle while m_axis_tready is high; five register stages, each with its own
// valid bit, so bubbles are filled while the output waits on tready.
// The integral accumulator closes its loop within a single stage.
// Reset clears all config registers, last error and the integral to zero.
// ----------------------------------------------------------------------------
module clamped_pid_with_angle_wrap
(
    input  logic                             clk,
    input  logic                             rst_n,
    // config write port
    input  logic                             cfg_we,
    input  logic [cpwa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cpwa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input items
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,   // [15:0] target, [31:16] measured
    // result items
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [15:0]                      m_axis_tdata    // [15:0] drive
);

    localparam int DW   = cpwa_pkg::DATA_W;
    localparam int EW   = cpwa_pkg::ERR_W;
    localparam int DEW  = cpwa_pkg::DERR_W;
    localparam int PW   = cpwa_pkg::PROD_W;
    localparam int DPW  = cpwa_pkg::DPROD_W;
    localparam int AW   = cpwa_pkg::ACC_W;
    localparam int IW   = cpwa_pkg::ISUM_W;
    localparam int PDW  = cpwa_pkg::PD_W;
    localparam int SW   = cpwa_pkg::SUM_W;
    localparam int FB   = cpwa_pkg::GAIN_FRAC_BITS;

    localparam logic signed [EW-1:0] TURN_E = EW'(cpwa_pkg::COUNTS_PER_TURN);
    localparam logic signed [EW-1:0] HALF_E = EW'(cpwa_pkg::HALF_TURN);

    cpwa_pkg::cfg_t cfg;

    cpwa_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ---------------- pipeline control ----------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic ld1, ld2, ld3, ld4;

    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign ld1 = v0_reg && rdy1;
    assign ld2 = v1_reg && rdy2;
    assign ld3 = v2_reg && rdy3;
    assign ld4 = v3_reg && rdy4;

    assign s_axis_tready = rdy0;
    assign m_axis_tvalid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= s_axis_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 0: input register ----------------
    logic signed [DW-1:0] tgt_reg, meas_reg;

    always_ff @(posedge clk)
    begin
        if (rdy0 && s_axis_tvalid)
        begin
            tgt_reg  <= $signed(s_axis_tdata[DW-1:0]);
            meas_reg <= $signed(s_axis_tdata[2*DW-1:DW]);
        end
    end

    // ---------------- stage 1: error, wrap, error delta ----------------
    // err_reg holds the error of the latest item and doubles as last error.
    logic signed [EW-1:0]  err_raw, err_next, err_reg;
    logic signed [DEW-1:0] derr_next, derr_reg;

    always_comb
    begin
        err_raw  = EW'(tgt_reg) - EW'(meas_reg);
        err_next = err_raw;
        if (cfg.angle_mode)
        begin
            if (err_raw > HALF_E)
                err_next = err_raw - TURN_E;
            else if (err_raw < -HALF_E)
                err_next = err_raw + TURN_E;
        end
        derr_next = DEW'(err_next) - DEW'(err_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_reg <= '0;
        else if (ld1)
            err_reg <= err_next;
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
            derr_reg <= derr_next;
    end

    // ---------------- stage 2: gain products ----------------
    logic signed [PW-1:0]  p_next, ip_next, p_reg, ip_reg;
    logic signed [DPW-1:0] dp_next, dp_reg;

    assign p_next  = PW'(cfg.prop_gain)  * PW'(err_reg);
    assign ip_next = PW'(cfg.integ_gain) * PW'(err_reg);
    assign dp_next = DPW'(cfg.deriv_gain) * DPW'(derr_reg);

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            p_reg  <= p_next;
            ip_reg <= ip_next;
            dp_reg <= dp_next;
        end
    end

    // ---------------- stage 3: integral with clamp, P + D ----------------
    logic signed [AW-1:0]  ilim, olim;
    logic signed [IW-1:0]  isum;
    logic signed [AW-1:0]  acc_next, acc_reg;
    logic signed [PDW-1:0] pd_next, pd_reg;

    assign ilim = $signed({1'b0, cfg.integ_limit, {FB{1'b0}}});
    assign olim = $signed({1'b0, cfg.out_limit, {FB{1'b0}}});

    always_comb
    begin
        isum = IW'(acc_reg) + IW'(ip_reg);
        if (isum > IW'(ilim))
            acc_next = ilim;
        else if (isum < -IW'(ilim))
            acc_next = -ilim;
        else
            acc_next = AW'(isum);
        pd_next = PDW'(p_reg) + PDW'(dp_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (ld3)
            acc_reg <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
            pd_reg <= pd_next;
    end

    // ---------------- stage 4: output clamp and floor shift ----------------
    logic signed [SW-1:0] sum_raw, sum_clamped;
    logic signed [DW-1:0] drive_next, drive_reg;

    always_comb
    begin
        sum_raw = SW'(pd_reg) + SW'(acc_reg);
        if (sum_raw > SW'(olim))
            sum_clamped = SW'(olim);
        else if (sum_raw < -SW'(olim))
            sum_clamped = -SW'(olim);
        else
            sum_clamped = sum_raw;
        // clamped value fits the integer range, so a slice is the floor shift
        drive_next = $signed(sum_clamped[FB +: DW]);
    end

    always_ff @(posedge clk)
    begin
        if (ld4)
            drive_reg <= drive_next;
    end

    assign m_axis_tdata = drive_reg;

    // ---------------- assertions ----------------
    a_acc_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ld3 |=> (acc_reg <= $past(ilim)) && (acc_reg >= -$past(ilim)))
        else $error("integral left its clamp range");

    a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ld4 |=> (drive_reg <= $signed({1'b0, $past(cfg.out_limit)}))
                && (drive_reg >= -$signed({1'b0, $past(cfg.out_limit)})))
        else $error("drive exceeds output limit");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!v0_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg) |-> s_axis_tready)
        else $error("empty pipeline refuses input");

    a_last_error_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !ld1 |=> $stable(err_reg))
        else $error("last error changed without a new item");

    a_acc_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !ld3 |=> $stable(acc_reg))
        else $error("integral changed without a new item");

endmodule
